>>> rtl/core/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU core.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package fpa_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [3:0] {
    MODE_ADD = 4'd0,
    MODE_SUB = 4'd1,
    MODE_MUL = 4'd2,
    MODE_DIV = 4'd3,
    MODE_LT  = 4'd4,
    MODE_GT  = 4'd5,
    MODE_LE  = 4'd6,
    MODE_GE  = 4'd7,
    MODE_EQ  = 4'd8,
    MODE_NE  = 4'd9,
    MODE_MIN = 4'd10,
    MODE_MAX = 4'd11,
    MODE_INC = 4'd12,
    MODE_DEC = 4'd13,
    MODE_I2F = 4'd14,
    MODE_F2I = 4'd15
  } mode_e;

  typedef struct packed {
    logic [3:0]               mode;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     compare_true;
    logic                     status_code;
  } out_t;

  // Control and finished results that ride along the divider chain.
  typedef struct packed {
    logic                     is_div;
    logic                     neg;
    logic signed [WORD_W-1:0] res;
    logic                     flag;
    logic                     status;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/fpa_front.sv
// Input stage of the ALU: decodes the mode, computes the operations other than
// multiply and divide, registers the multiplier product and prepares divider operands.
// Depends on fpa_pkg.
`default_nettype none

module fpa_front #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  valid_i,
  output logic                                 ready_o,
  input  fpa_pkg::in_t                         in_i,
  output logic                                 valid_o,
  input  wire                                  ready_i,
  output fpa_pkg::cell_ctl_t                   ctl_o,
  output logic [fpa_pkg::WORD_W+FRAC_BITS-1:0] dq_o,
  output logic [fpa_pkg::WORD_W-1:0]           dvs_o
);
  import fpa_pkg::*;

  localparam int unsigned DW = WORD_W + FRAC_BITS;
  localparam logic [WORD_W-1:0] RND = (WORD_W'(1) << FRAC_BITS) - WORD_W'(1);

  logic signed [WORD_W-1:0]   a, b;
  logic signed [2*WORD_W-1:0] prod_d, prod_q;
  logic signed [WORD_W-1:0]   f2i_sum;
  logic [WORD_W-1:0]          abs_a, abs_b;
  logic signed [WORD_W-1:0]   res_d, res_q;
  logic                       flag_d, flag_q, stat_d, stat_q;
  logic                       is_div_d, is_div_q, is_mul_d, is_mul_q, neg_q;
  logic [DW-1:0]              dvd_q;
  logic [WORD_W-1:0]          dvs_q;
  logic                       valid_q;

  assign a       = in_i.operand_a;
  assign b       = in_i.operand_b;
  assign prod_d  = a * b;
  // Negative values get a bias so the shift truncates toward zero.
  assign f2i_sum = a + (a[WORD_W-1] ? $signed(RND) : $signed(WORD_W'(0)));
  assign abs_a   = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
  assign abs_b   = b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);

  always_comb begin
    res_d    = '0;
    flag_d   = 1'b0;
    stat_d   = 1'b0;
    is_div_d = 1'b0;
    is_mul_d = 1'b0;
    unique case (mode_e'(in_i.mode))
      MODE_ADD: res_d = a + b;
      MODE_SUB: res_d = a - b;
      MODE_MUL: is_mul_d = 1'b1;
      MODE_DIV: begin
        is_div_d = 1'b1;
        stat_d   = (b == '0);
      end
      MODE_LT:  flag_d = (a < b);
      MODE_GT:  flag_d = (a > b);
      MODE_LE:  flag_d = (a <= b);
      MODE_GE:  flag_d = (a >= b);
      MODE_EQ:  flag_d = (a == b);
      MODE_NE:  flag_d = (a != b);
      MODE_MIN: res_d = (a < b) ? a : b;
      MODE_MAX: res_d = (a > b) ? a : b;
      MODE_INC: res_d = a + WORD_W'(1);
      MODE_DEC: res_d = a - WORD_W'(1);
      MODE_I2F: res_d = a <<< FRAC_BITS;
      MODE_F2I: res_d = f2i_sum >>> FRAC_BITS;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q   <= prod_d;
      res_q    <= res_d;
      flag_q   <= flag_d;
      stat_q   <= stat_d;
      is_div_q <= is_div_d;
      is_mul_q <= is_mul_d;
      neg_q    <= a[WORD_W-1] ^ b[WORD_W-1];
      dvd_q    <= {abs_a, {FRAC_BITS{1'b0}}};
      dvs_q    <= abs_b;
    end
  end

  // The product shifted right by FRAC_BITS, low word kept.
  always_comb begin
    ctl_o.is_div = is_div_q;
    ctl_o.neg    = neg_q;
    ctl_o.res    = is_mul_q ? prod_q[FRAC_BITS+WORD_W-1:FRAC_BITS] : res_q;
    ctl_o.flag   = flag_q;
    ctl_o.status = stat_q;
  end

  assign valid_o = valid_q;
  assign dq_o    = dvd_q;
  assign dvs_o   = dvs_q;

endmodule

`default_nettype wire

>>> rtl/core/fpa_div_cell.sv
// One cell of the divider chain: a restoring step that produces one quotient
// bit and hands remainder, shifted dividend/quotient and control onward.
// Depends on fpa_pkg.
`default_nettype none

module fpa_div_cell #(
  parameter int unsigned DW = 40
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          valid_i,
  output logic                         ready_o,
  input  fpa_pkg::cell_ctl_t           ctl_i,
  input  wire  [DW-1:0]                dq_i,
  input  wire  [fpa_pkg::WORD_W-1:0]   rem_i,
  input  wire  [fpa_pkg::WORD_W-1:0]   dvs_i,
  output logic                         valid_o,
  input  wire                          ready_i,
  output fpa_pkg::cell_ctl_t           ctl_o,
  output logic [DW-1:0]                dq_o,
  output logic [fpa_pkg::WORD_W-1:0]   rem_o,
  output logic [fpa_pkg::WORD_W-1:0]   dvs_o
);
  import fpa_pkg::*;

  logic [WORD_W:0]   trial, diff;
  logic              qbit;
  logic              valid_q;
  cell_ctl_t         ctl_q;
  logic [DW-1:0]     dq_q;
  logic [WORD_W-1:0] rem_q, dvs_q;

  // The remainder stays below the divisor, so the trial value fits in WORD_W+1 bits
  // and the top bit of the difference is the borrow.
  assign trial = {rem_i, dq_i[DW-1]};
  assign diff  = trial - {1'b0, dvs_i};
  assign qbit  = !diff[WORD_W];

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctl_q <= ctl_i;
      dq_q  <= {dq_i[DW-2:0], qbit};
      rem_q <= qbit ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      dvs_q <= dvs_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign dq_o    = dq_q;
  assign rem_o   = rem_q;
  assign dvs_o   = dvs_q;

endmodule

`default_nettype wire

>>> rtl/core/fpa_tail.sv
// Output register of the ALU: applies the quotient sign, selects the final
// result word and holds the item until the consumer takes it.
// Depends on fpa_pkg.
`default_nettype none

module fpa_tail #(
  parameter int unsigned DW = 40
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  fpa_pkg::cell_ctl_t  ctl_i,
  input  wire  [DW-1:0]       dq_i,
  output logic                valid_o,
  input  wire                 stall_i,
  output fpa_pkg::out_t       out_o
);
  import fpa_pkg::*;

  logic [WORD_W-1:0] quo;
  out_t              out_d, out_q;
  logic              valid_q;

  assign quo = dq_i[WORD_W-1:0];

  always_comb begin
    out_d.compare_true = ctl_i.flag;
    out_d.status_code  = ctl_i.status;
    if (!ctl_i.is_div) begin
      out_d.result_value = ctl_i.res;
    end else if (ctl_i.status) begin
      out_d.result_value = '0;
    end else begin
      out_d.result_value = ctl_i.neg ? $signed(-quo) : $signed(quo);
    end
  end

  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

>>> rtl/core/fixed_point_q24_8_alu_core.sv
// Signed Q24.8 fixed-point ALU with one input stage, one divider cell per
// quotient bit and one output stage. Throughput is one item per cycle while
// out_stall_i is low; every stage is a holding register that fills bubbles, so
// the chain of 32 + FRAC_BITS divider cells sets the depth.
// Reset clears only the valid bits; the block keeps no state between items.
// Depends on fpa_pkg, fpa_front, fpa_div_cell and fpa_tail.
`default_nettype none

module fixed_point_q24_8_alu_core #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  fpa_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output fpa_pkg::out_t  out_o
);
  import fpa_pkg::*;

  localparam int unsigned DW = WORD_W + FRAC_BITS;

  logic              front_ready;
  logic              vld_c [DW+1];
  logic              rdy_c [DW+1];
  cell_ctl_t         ctl_c [DW+1];
  logic [DW-1:0]     dq_c  [DW+1];
  logic [WORD_W-1:0] rem_c [DW+1];
  logic [WORD_W-1:0] dvs_c [DW+1];

  assign in_stall_o = !front_ready;
  assign rem_c[0]   = '0;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .in_i    (in_i),
    .valid_o (vld_c[0]),
    .ready_i (rdy_c[0]),
    .ctl_o   (ctl_c[0]),
    .dq_o    (dq_c[0]),
    .dvs_o   (dvs_c[0])
  );

  for (genvar k = 0; k < DW; k++) begin : g_cell
    fpa_div_cell #(.DW(DW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_c[k]),
      .ready_o (rdy_c[k]),
      .ctl_i   (ctl_c[k]),
      .dq_i    (dq_c[k]),
      .rem_i   (rem_c[k]),
      .dvs_i   (dvs_c[k]),
      .valid_o (vld_c[k+1]),
      .ready_i (rdy_c[k+1]),
      .ctl_o   (ctl_c[k+1]),
      .dq_o    (dq_c[k+1]),
      .rem_o   (rem_c[k+1]),
      .dvs_o   (dvs_c[k+1])
    );
  end

  fpa_tail #(.DW(DW)) u_tail (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_c[DW]),
    .ready_o (rdy_c[DW]),
    .ctl_i   (ctl_c[DW]),
    .dq_i    (dq_c[DW]),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .out_o   (out_o)
  );

  // A division by zero never reports a comparison and always gives a zero word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status_code |-> !out_o.compare_true)
    else $error("status and compare flag both set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status_code |-> out_o.result_value == '0)
    else $error("division by zero with nonzero result");

  // Comparison modes leave the result word at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.compare_true |-> out_o.result_value == '0)
    else $error("comparison with nonzero result");

  // The input stage holds its item while the first divider cell is not ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_c[0] && !rdy_c[0] |=> vld_c[0])
    else $error("input stage dropped an item");

endmodule

`default_nettype wire
